// ===== sv/fmul_pkg.sv =====
// fmul_pkg: constants and helpers for the binary32 multiplier
// no dependencies

package fmul_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned FracBits   = 23;
   localparam int unsigned ExpBits    = 8;
   localparam int unsigned SigBits    = FracBits + 1;

   localparam logic [WordWidth-1:0] QnanBits = 32'h7FC0_0000;
   localparam logic [ExpBits-1:0]   ExpAllOnes = 8'hFF;

   // biased exponent sum limits: e = ea + eb - 254, need -126 <= e <= 127
   // so biased result ea + eb - 127 must be in [1, 254]
   localparam logic [ExpBits+1:0] ExpBias = 10'd127;

   // special-case class decided in the front stage
   typedef enum logic [2:0] {
      CLS_NORMAL = 3'b001,
      CLS_ZERO   = 3'b010,
      CLS_INF    = 3'b100
   } class_type;

   typedef struct packed {
      logic             nan;
      class_type        cls;
      logic             sign;
      logic [ExpBits+1:0] exp_sum;  // ea + eb, unsigned
   } ctl_type;

endpackage

// ===== sv/fmul_if.sv =====
// fmul_if: valid/ready channel carrying one 32-bit word pair or word
// depends on fmul_pkg for the word width

interface fmul_req_if;
   logic                          valid;
   logic                          ready;
   logic [fmul_pkg::WordWidth-1:0] operand_a;
   logic [fmul_pkg::WordWidth-1:0] operand_b;
   modport source (output valid, output operand_a, output operand_b, input ready);
   modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface fmul_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fmul_pkg::WordWidth-1:0] product;
   modport source (output valid, output product, input ready);
   modport sink   (input valid, input product, output ready);
endinterface

// ===== sv/float32_multiplier.sv =====
// float32_multiplier: pipelined IEEE binary32 multiply, truncating toward zero
// depends on fmul_pkg and fmul_if
//
// One multiply enters per cycle unless the result side stalls, and stage 1
// decodes operands and classifies special cases, stage 2 forms the
// two 24x12 partial products, stage 3 adds them, stage 4 normalizes and
// packs. The whole pipe advances when the output stage is empty or taken,
// so a stall on the result side holds every stage and nothing is lost.
// Zero and subnormal inputs are treated as zero, subnormal results flush to
// zero and any NaN result is the canonical quiet NaN 0x7FC00000.

module float32_multiplier (
   input  logic         clock,
   input  logic         reset,
   fmul_req_if.sink     req,
   fmul_rsp_if.source   rsp
);
   import fmul_pkg::*;

   logic advance;

   // stage valid bits
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   // stage 1 payload
   ctl_type            c1_ff, c1_in;
   logic [SigBits-1:0] sa1_ff, sb1_ff;

   // stage 2 payload: partial products over low and high halves of b
   ctl_type             c2_ff;
   logic [SigBits+11:0] pl2_ff, ph2_ff;

   // stage 3 payload
   ctl_type              c3_ff;
   logic [2*SigBits-1:0] prod3_ff, prod3_in;

   // stage 4 payload
   logic [WordWidth-1:0] res4_ff, res4_in;

   assign advance   = !v4_ff || rsp.ready;
   assign req.ready = advance;
   assign rsp.valid = v4_ff;
   assign rsp.product = res4_ff;

   // decode and classify
   always_comb begin
      logic [ExpBits-1:0] ea, eb;
      logic nan_a, nan_b, inf_a, inf_b, zer;
      ea = req.operand_a[30:23];
      eb = req.operand_b[30:23];
      nan_a = (ea == ExpAllOnes) && (req.operand_a[22:0] != '0);
      nan_b = (eb == ExpAllOnes) && (req.operand_b[22:0] != '0);
      inf_a = (ea == ExpAllOnes) && (req.operand_a[22:0] == '0);
      inf_b = (eb == ExpAllOnes) && (req.operand_b[22:0] == '0);
      zer   = (ea == '0) || (eb == '0);
      c1_in.sign    = req.operand_a[31] ^ req.operand_b[31];
      c1_in.exp_sum = {2'b00, ea} + {2'b00, eb};
      c1_in.nan     = nan_a || nan_b || ((inf_a || inf_b) && zer);
      if (inf_a || inf_b) begin
         c1_in.cls = CLS_INF;
      end else if (zer) begin
         c1_in.cls = CLS_ZERO;
      end else begin
         c1_in.cls = CLS_NORMAL;
      end
   end

   // add partial products
   assign prod3_in = {{(SigBits-12){1'b0}}, pl2_ff} + {ph2_ff, 12'b0};

   // normalize, range check and pack
   always_comb begin
      logic [SigBits:0]   sig;
      logic [ExpBits+1:0] e;
      sig = prod3_ff[2*SigBits-1:FracBits];
      e   = c3_ff.exp_sum;
      if (sig[SigBits]) begin
         sig = sig >> 1;
         e   = e + 10'd1;
      end
      if (c3_ff.nan) begin
         res4_in = QnanBits;
      end else begin
         case (c3_ff.cls)
            CLS_INF:  res4_in = {c3_ff.sign, ExpAllOnes, 23'b0};
            CLS_ZERO: res4_in = {c3_ff.sign, 31'b0};
            default: begin
               if (e > ExpBias + 10'd254) begin
                  res4_in = {c3_ff.sign, ExpAllOnes, 23'b0};
               end else if (e < ExpBias + 10'd1) begin
                  res4_in = {c3_ff.sign, 31'b0};
               end else begin
                  res4_in = {c3_ff.sign, 8'(e - ExpBias), sig[FracBits-1:0]};
               end
            end
         endcase
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (advance) begin
         c1_ff    <= c1_in;
         sa1_ff   <= {1'b1, req.operand_a[22:0]};
         sb1_ff   <= {1'b1, req.operand_b[22:0]};
         c2_ff    <= c1_ff;
         pl2_ff   <= sa1_ff * sb1_ff[11:0];
         ph2_ff   <= sa1_ff * sb1_ff[23:12];
         c3_ff    <= c2_ff;
         prod3_ff <= prod3_in;
         res4_ff  <= res4_in;
      end
   end

   // a held result stays put while the sink stalls
   assert property (@(posedge clock) disable iff (reset)
      v4_ff && !rsp.ready |=> v4_ff && $stable(res4_ff))
      else $error("held result changed");

   // a transaction accepted reaches stage 1 after an advancing edge
   assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> v1_ff)
      else $error("accepted transaction dropped");

   // nan results carry the canonical pattern
   assert property (@(posedge clock) disable iff (reset)
      advance && v3_ff && c3_ff.nan |=> res4_ff == QnanBits)
      else $error("nan result not canonical");

endmodule
